// File: rtl/crt_pkg.sv
// ----------------------------------------------------------------------------
// crt_pkg: shared constants and tables for the cosine ramp trajectory
// Fixed-point constants, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int FRAC_BITS     = 16;

  // pi in Q30, CORDIC limit gain in Q30, one in Q30
  localparam logic [31:0]        PI_Q30   = 32'd3373259426;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;

  // rounding shifts for velocity and the second acceleration product
  localparam int VEL_SHIFT = 91 - FRAC_BITS;
  localparam int ACC_SHIFT = 91 - 2 * FRAC_BITS;

  // width of the pi/D quotient
  localparam int W_BITS = 63;

  // configuration register indexes
  localparam logic [1:0] CFG_START    = 2'd0;
  localparam logic [1:0] CFG_END      = 2'd1;
  localparam logic [1:0] CFG_DURATION = 2'd2;

  // atan(2^-i) in Q30
  function automatic logic [31:0] atan_q30(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd843314857;
      1:  v = 32'd497837829;
      2:  v = 32'd263043837;
      3:  v = 32'd133525159;
      4:  v = 32'd67021687;
      5:  v = 32'd33543516;
      6:  v = 32'd16775851;
      7:  v = 32'd8388437;
      8:  v = 32'd4194283;
      9:  v = 32'd2097149;
      10: v = 32'd1048576;
      11: v = 32'd524288;
      12: v = 32'd262144;
      13: v = 32'd131072;
      14: v = 32'd65536;
      15: v = 32'd32768;
      16: v = 32'd16384;
      17: v = 32'd8192;
      18: v = 32'd4096;
      19: v = 32'd2048;
      20: v = 32'd1024;
      21: v = 32'd512;
      22: v = 32'd256;
      23: v = 32'd128;
      24: v = 32'd64;
      25: v = 32'd32;
      26: v = 32'd16;
      27: v = 32'd8;
      28: v = 32'd4;
      29: v = 32'd2;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/crt_mul64.sv
// ----------------------------------------------------------------------------
// crt_mul64: two-stage 64 x 64 unsigned multiplier
// First stage forms four 32 x 32 partial products, second stage sums them.
// ----------------------------------------------------------------------------
module crt_mul64 import crt_pkg::*; (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic [127:0] p_o
);

  logic [63:0]  p00_q, p01_q, p10_q, p11_q;
  logic [127:0] p_q;

  // form partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q <= 64'(a_i[31:0])  * 64'(b_i[31:0]);
      p01_q <= 64'(a_i[31:0])  * 64'(b_i[63:32]);
      p10_q <= 64'(a_i[63:32]) * 64'(b_i[31:0]);
      p11_q <= 64'(a_i[63:32]) * 64'(b_i[63:32]);
    end
  end

  // sum partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= {64'd0, p00_q} + {32'd0, p01_q, 32'd0} + {32'd0, p10_q, 32'd0}
             + {p11_q, 64'd0};
    end
  end

  assign p_o = p_q;

endmodule

// File: rtl/cosine_ramp_trajectory.sv
// Throughput: one item per cycle while the pi/D divider is idle; the whole pipeline holds while a result is stalled.
// After reset, and after each write of move_duration, pi/D is worked out by a
// one-bit-per-cycle divider; in_stall_o is high while it runs.
// Reset: start 0, end 0, duration 1.0; no items in flight.
// ----------------------------------------------------------------------------
// cosine_ramp_trajectory: raised-cosine move point generator
// Pipelined divider, fold, CORDIC and scaling multipliers giving position,
// velocity and acceleration of a raised-cosine move, with saturation flag.
// ----------------------------------------------------------------------------
module cosine_ramp_trajectory import crt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] sample_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] position_o,
  output logic signed [31:0] velocity_o,
  output logic signed [31:0] acceleration_o,
  output logic        saturated_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int CS   = CORDIC_STAGES;
  localparam int DIVN = 33;
  localparam int LAT  = 44 + CS;
  localparam int S_FOLD  = DIVN + 1;
  localparam int S_CLAMP = 36 + CS;

  // configuration registers
  logic signed [31:0] s_q, e_q;
  logic [31:0]        d_q;

  // pi/D divider
  logic              busy_q;
  logic [5:0]        wcnt_q;
  logic [31:0]       wrem_q;
  logic [W_BITS-1:0] wquo_q;
  logic [W_BITS-1:0] num_w;
  logic [32:0]       wtrial;
  logic              wge;
  logic [63:0]       w64;

  // pipeline control
  logic en, accept, past_in;
  logic vld_q  [0:LAT-1];
  logic past_q [0:LAT-1];

  // accept config writes at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0;
      e_q <= '0;
      d_q <= 32'(64'd1 << FRAC_BITS);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_START:    s_q <= cfg_data_i;
        CFG_END:      e_q <= cfg_data_i;
        CFG_DURATION: d_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // work out W = round(pi * 2^30 / D), one quotient bit a cycle
  assign num_w  = W_BITS'({PI_Q30, 30'd0}) + W_BITS'(d_q[31:1]);
  assign wtrial = {wrem_q, num_w[wcnt_q]};
  assign wge    = wtrial >= {1'b0, d_q};
  assign w64    = 64'(wquo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      wcnt_q <= 6'(W_BITS - 1);
      wrem_q <= '0;
      wquo_q <= '0;
    end else if (cfg_valid_i && cfg_index_i == CFG_DURATION) begin
      busy_q <= 1'b1;
      wcnt_q <= 6'(W_BITS - 1);
      wrem_q <= '0;
      wquo_q <= '0;
    end else if (busy_q) begin
      wrem_q <= wge ? 32'(wtrial - {1'b0, d_q}) : wtrial[31:0];
      wquo_q <= {wquo_q[W_BITS-2:0], wge};
      wcnt_q <= wcnt_q - 6'd1;
      if (wcnt_q == 6'd0) begin
        busy_q <= 1'b0;
      end
    end
  end

  // advance the whole pipeline unless the result is held
  assign en         = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o = !en || busy_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign past_in    = (d_q == 32'd0) || (sample_time_i > d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= accept;
      for (int k = 1; k < LAT; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      past_q[0] <= past_in;
      for (int k = 1; k < LAT; k++) past_q[k] <= past_q[k-1];
    end
  end

  // phase divider: r = round(t * 2^32 / D), one quotient bit per stage
  logic [31:0] drem_q [0:DIVN];
  logic [32:0] dnum_q [0:DIVN];
  logic [32:0] dquo_q [0:DIVN];

  always_ff @(posedge clk_i) begin
    if (en) begin
      drem_q[0] <= {1'b0, sample_time_i[31:1]};
      dnum_q[0] <= {sample_time_i[0], d_q[31:0] >> 1};
      dquo_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < DIVN; k++) begin : g_div
    logic [32:0] trial;
    logic        ge;
    assign trial = {drem_q[k], dnum_q[k][32]};
    assign ge    = trial >= {1'b0, d_q};
    always_ff @(posedge clk_i) begin
      if (en) begin
        drem_q[k+1] <= ge ? 32'(trial - {1'b0, d_q}) : trial[31:0];
        dnum_q[k+1] <= {dnum_q[k][31:0], 1'b0};
        dquo_q[k+1] <= {dquo_q[k][31:0], ge};
      end
    end
  end

  // fold the phase into the first quarter turn
  logic        flip_q;
  logic [31:0] rf_q;
  logic [32:0] r_w;
  logic        flip_w;
  logic [63:0] ang_prod;

  assign r_w    = dquo_q[DIVN];
  assign flip_w = r_w > 33'h080000000;

  always_ff @(posedge clk_i) begin
    if (en) begin
      flip_q <= flip_w;
      rf_q   <= flip_w ? 32'(33'h100000000 - r_w) : r_w[31:0];
    end
  end

  // angle in Q30 radians
  assign ang_prod = (64'(rf_q) * 64'(PI_Q30)) + 64'h80000000;

  logic signed [33:0] cx_q [0:CS];
  logic signed [33:0] cy_q [0:CS];
  logic signed [32:0] cz_q [0:CS];
  logic               cflip_q [0:CS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q[0]    <= GAIN_Q30;
      cy_q[0]    <= '0;
      cz_q[0]    <= $signed({1'b0, ang_prod[63:32]});
      cflip_q[0] <= flip_q;
    end
  end

  // rotation stages
  for (genvar i = 0; i < CS; i++) begin : g_cordic
    logic signed [32:0] at;
    assign at = $signed({1'b0, atan_q30(i)});
    always_ff @(posedge clk_i) begin
      if (en) begin
        cflip_q[i+1] <= cflip_q[i];
        if (cz_q[i] >= 0) begin
          cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] - at;
        end else begin
          cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] + at;
        end
      end
    end
  end

  // negate for the second quarter turn and clamp to one
  logic signed [33:0] xf, xc, yc;
  logic signed [31:0] cos_q, sin_q;

  assign xf = cflip_q[CS] ? -cx_q[CS] : cx_q[CS];

  always_comb begin
    xc = xf;
    if (xf > ONE_Q30) xc = ONE_Q30;
    if (xf < -ONE_Q30) xc = -ONE_Q30;
    yc = cy_q[CS];
    if (cy_q[CS] > ONE_Q30) yc = ONE_Q30;
    if (cy_q[CS] < -ONE_Q30) yc = -ONE_Q30;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cos_q <= 32'(xc);
      sin_q <= 32'(yc);
    end
  end

  // magnitudes and first products
  logic signed [32:0] delta;
  logic [32:0]        dabs;
  logic [31:0]        dmag, cmag, smag, onemx;
  logic signed [32:0] onemx_w;
  logic [63:0]        av_q, ac_q, qp_q;
  logic               dneg_q, xneg_q, yneg_q;

  assign delta   = 33'(e_q) - 33'(s_q);
  assign dabs    = delta[32] ? 33'(-delta) : 33'(delta);
  assign dmag    = dabs[31:0];
  assign cmag    = cos_q[31] ? 32'(-cos_q) : 32'(cos_q);
  assign smag    = sin_q[31] ? 32'(-sin_q) : 32'(sin_q);
  assign onemx_w = 33'(ONE_Q30) - 33'(cos_q);
  assign onemx   = onemx_w[31:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      av_q   <= 64'(dmag) * 64'(smag);
      ac_q   <= 64'(dmag) * 64'(cmag);
      qp_q   <= 64'(dmag) * 64'(onemx);
      dneg_q <= delta[32];
      xneg_q <= cos_q[31];
      yneg_q <= sin_q[31];
    end
  end

  // scale by pi/D
  logic [127:0] pv, pc, pa;
  logic [63:0]  qp1_q, qp2_q;
  logic [1:0]   dn_q, xn_q, yn_q;

  crt_mul64 u_mul_vel (.clk_i(clk_i), .en_i(en), .a_i(av_q), .b_i(w64), .p_o(pv));
  crt_mul64 u_mul_acc1 (.clk_i(clk_i), .en_i(en), .a_i(ac_q), .b_i(w64), .p_o(pc));

  always_ff @(posedge clk_i) begin
    if (en) begin
      qp1_q <= qp_q;
      qp2_q <= qp1_q;
      dn_q  <= {dn_q[0], dneg_q};
      xn_q  <= {xn_q[0], xneg_q};
      yn_q  <= {yn_q[0], yneg_q};
    end
  end

  // round position and velocity, take first acceleration term
  logic [127:0]       sumv, vmag, vlim, sumc;
  logic               vneg, vsat;
  logic [31:0]        vm;
  logic [63:0]        sumq;
  logic signed [33:0] qs, pos;
  logic               psat;
  logic signed [31:0] pout;
  logic [63:0]        c1_q;
  logic signed [31:0] pos4_q, vel4_q;
  logic               sat4_q, aneg4_q;

  assign sumv = pv + (128'd1 << (VEL_SHIFT - 1));
  assign vmag = sumv >> VEL_SHIFT;
  assign vneg = (vmag != 128'd0) && (dn_q[1] != yn_q[1]);
  assign vlim = vneg ? 128'h80000000 : 128'h7FFFFFFF;
  assign vsat = vmag > vlim;
  assign vm   = vsat ? vlim[31:0] : vmag[31:0];

  assign sumq = qp2_q + 64'h40000000;
  assign qs   = $signed({1'b0, sumq[63:31]});
  assign pos  = 34'(s_q) + (dn_q[1] ? -qs : qs);
  assign psat = (pos > 34'sd2147483647) || (pos < -34'sd2147483648);

  always_comb begin
    pout = pos[31:0];
    if (pos > 34'sd2147483647) pout = 32'sh7FFFFFFF;
    if (pos < -34'sd2147483648) pout = 32'sh80000000;
  end

  assign sumc = pc + (128'd1 << 59);

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q    <= sumc[123:60];
      pos4_q  <= pout;
      vel4_q  <= vneg ? 32'(-vm) : 32'(vm);
      sat4_q  <= psat || vsat;
      aneg4_q <= dn_q[1] != xn_q[1];
    end
  end

  crt_mul64 u_mul_acc2 (.clk_i(clk_i), .en_i(en), .a_i(c1_q), .b_i(w64), .p_o(pa));

  logic signed [31:0] pos5_q [0:1];
  logic signed [31:0] vel5_q [0:1];
  logic [1:0]         sat5_q, aneg5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos5_q[0] <= pos4_q;
      pos5_q[1] <= pos5_q[0];
      vel5_q[0] <= vel4_q;
      vel5_q[1] <= vel5_q[0];
      sat5_q    <= {sat5_q[0], sat4_q};
      aneg5_q   <= {aneg5_q[0], aneg4_q};
    end
  end

  // round acceleration, saturate and register the result, or the end point once past the move
  logic [127:0] suma, amag, alim;
  logic         aneg, asat;
  logic [31:0]  am;
  logic signed [31:0] pos_q, vel_q, acc_q;
  logic         sat_q;

  assign suma = pa + (128'd1 << (ACC_SHIFT - 1));
  assign amag = suma >> ACC_SHIFT;
  assign aneg = (amag != 128'd0) && aneg5_q[1];
  assign alim = aneg ? 128'h80000000 : 128'h7FFFFFFF;
  assign asat = amag > alim;
  assign am   = asat ? alim[31:0] : amag[31:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (past_q[LAT-2]) begin
        pos_q <= e_q;
        vel_q <= '0;
        acc_q <= '0;
        sat_q <= 1'b0;
      end else begin
        pos_q <= pos5_q[1];
        vel_q <= vel5_q[1];
        acc_q <= aneg ? 32'(-am) : 32'(am);
        sat_q <= sat5_q[1] || asat;
      end
    end
  end

  assign out_valid_o    = vld_q[LAT-1];
  assign position_o     = pos_q;
  assign velocity_o     = vel_q;
  assign acceleration_o = acc_q;
  assign saturated_o    = sat_q;

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> in_stall_o)
    else $error("item accepted while pi/D divider busy");

  a_dur_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && cfg_index_i == CFG_DURATION |=> busy_q)
    else $error("duration write did not restart divider");

  a_past_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && past_q[LAT-1] |-> !saturated_o && velocity_o == 32'sd0)
    else $error("finished move gave nonzero velocity or saturation");

  a_clamp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[S_CLAMP] && !past_q[S_CLAMP] |->
      (34'(cos_q) <= ONE_Q30) && (34'(cos_q) >= -ONE_Q30) && (rf_q <= 32'h80000000
      || !vld_q[S_FOLD] || past_q[S_FOLD]))
    else $error("clamped cosine or folded phase out of range");
`endif

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the cosine ramp trajectory
// Drives time samples under several move settings, predicts each trajectory
// point in fixed point and compares every result field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  import crt_pkg::*;

  localparam logic [1:0]  CFG_SPARE  = 2'd3;     // index past the register list
  localparam logic [63:0] PI_Q30_W   = 64'd3373259426;
  localparam longint      GAIN_Q30_L = 652032874;
  localparam longint      ONE_Q30_L  = 1073741824;
  localparam int          VEL_SH     = 75;
  localparam int          ACC_SH     = 59;
  localparam int          LAT_WAIT   = 70;
  localparam int          CYCLE_CAP  = 600000;
  localparam int          PHASES     = 12;
  localparam int          PER_PHASE  = 60;

  localparam longint ATAN_Q30 [16] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768
  };

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] acc;
    logic               sat;
  } point_t;

  typedef struct {
    logic [31:0] s, e, d, t;
    bit          typed;
    point_t      want;
  } row_t;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o;
  logic [31:0] sample_time_i;
  logic        out_valid_o, out_stall_i;
  logic signed [31:0] position_o, velocity_o, acceleration_o;
  logic        saturated_o;
  logic        cfg_valid_i, cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  cosine_ramp_trajectory uut (.*);

  // mirror of the move registers
  logic signed [31:0] start_pos, end_pos;
  logic [31:0]        dur;

  point_t      points_due [$];
  int          errors;
  int          cycles;
  bit          quiet;
  int          gap_odds;
  int          stall_left;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [127:0] round_shift(input logic [127:0] v, input int n);
    return (v + (128'd1 << (n - 1))) >> n;
  endfunction

  function automatic logic [31:0] clip(input logic [127:0] mag, input bit neg,
                                       inout bit sat);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (mag > lim) begin
      sat = 1'b1;
      mag = lim;
    end
    return neg ? (32'd0 - mag[31:0]) : mag[31:0];
  endfunction

  // trajectory point for one sample time under the current registers
  function automatic point_t move_point(input logic [31:0] t);
    logic [63:0]  d, r, rf, dmag, cmag, smag, w, q, acc1;
    longint       x, y, z, dx, dy, delta, pos;
    bit           flip, dneg, sat;
    logic [127:0] m;
    point_t       p;
    d = {32'd0, dur};
    if (d == 0 || {32'd0, t} > d) begin
      p.pos = end_pos; p.vel = '0; p.acc = '0; p.sat = 1'b0;
      return p;
    end
    r = (({32'd0, t} << 32) + (d >> 1)) / d;
    flip = r > 64'h8000_0000;
    rf = flip ? ((64'd1 << 32) - r) : r;
    z = longint'((rf * PI_Q30_W + 64'h8000_0000) >> 32);
    x = GAIN_Q30_L;
    y = 0;
    // rotate towards the phase
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_Q30[i];
      end else begin
        x += dx; y -= dy; z += ATAN_Q30[i];
      end
    end
    if (flip) x = -x;
    if (x > ONE_Q30_L) x = ONE_Q30_L;
    if (x < -ONE_Q30_L) x = -ONE_Q30_L;
    if (y > ONE_Q30_L) y = ONE_Q30_L;
    if (y < -ONE_Q30_L) y = -ONE_Q30_L;
    delta = longint'(end_pos) - longint'(start_pos);
    dneg = delta < 0;
    dmag = dneg ? -delta : delta;
    cmag = x < 0 ? -x : x;
    smag = y < 0 ? -y : y;
    sat = 1'b0;
    q = (dmag * 64'(ONE_Q30_L - x) + (64'd1 << 30)) >> 31;
    pos = longint'(start_pos) + (dneg ? -longint'(q) : longint'(q));
    p.pos = clip(128'(pos < 0 ? -pos : pos), pos < 0, sat);
    w = ((PI_Q30_W << 30) + (d >> 1)) / d;
    m = round_shift(128'(dmag * smag) * 128'(w), VEL_SH);
    p.vel = clip(m, m[63:0] != 0 && (dneg != (y < 0)), sat);
    m = round_shift(128'(dmag * cmag) * 128'(w), 60);
    acc1 = m[63:0];
    m = round_shift(128'(acc1) * 128'(w), ACC_SH);
    p.acc = clip(m, m != 0 && (dneg != (x < 0)), sat);
    p.sat = sat;
    return p;
  endfunction

  // compare each result with the oldest point due
  always @(posedge clk_i) begin
    point_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{position_o, velocity_o, acceleration_o, saturated_o};
      if (points_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item pos=%0d", position_o);
      end else begin
        want = points_due.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: want pos=%0d vel=%0d acc=%0d sat=%0b, got %0d %0d %0d %0b",
                     want.pos, want.vel, want.acc, want.sat,
                     got.pos, got.vel, got.acc, got.sat);
        end
      end
    end
  end

  // stall the result side in bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= stall_left > 1;
    end else if ($urandom_range(9, 0) == 0) begin
      stall_left  <= $urandom_range(19, 1);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // offer one register write; the caller drops cfg_valid_i after the last one
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_START:    start_pos = val;
      CFG_END:      end_pos   = val;
      CFG_DURATION: dur       = val;
      default: ;
    endcase
  endtask

  // hold until every point has arrived and the pipeline is empty
  task automatic drain();
    while (points_due.size() != 0) @(posedge clk_i);
    repeat (LAT_WAIT) @(posedge clk_i);
  endtask

  task automatic set_move(input logic [31:0] s, e, d);
    drain();
    write_reg(CFG_START, s);
    write_reg(CFG_END, e);
    write_reg(CFG_DURATION, d);
    cfg_valid_i <= 1'b0;
  endtask

  // offer one sample, with an occasional gap in front
  task automatic send_sample(input logic [31:0] t, input bit typed, input point_t want);
    int n;
    if (!quiet && gap_odds != 0 && $urandom_range(gap_odds, 0) == 0) begin
      in_valid_i <= 1'b0;
      n = $urandom_range(19, 1);
      repeat (n) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_time_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    points_due.push_back(typed ? want : move_point(t));
  endtask

  function automatic logic [31:0] pick_pos();
    case ($urandom_range(3, 0))
      0:       return $urandom_range(32'h000F_FFFF, 0);
      1:       return 32'd0 - $urandom_range(32'h000F_FFFF, 0);
      2:       return $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_dur();
    case ($urandom_range(7, 0))
      0:       return 32'd1;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd0;
      3, 4:    return $urandom_range(32'h000A_0000, 32'h0000_4000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_time();
    case ($urandom_range(9, 0))
      0:       return dur;
      1:       return $urandom;
      2:       return dur + $urandom_range(3, 1);
      default: return $urandom_range(dur, 0);
    endcase
  endfunction

  initial begin
    row_t   rows [$];
    point_t none;
    none = '0;
    rows = '{
      // reset registers: still move at zero, then past the end
      '{32'd0, 32'd0, 32'h0001_0000, 32'd0, 1, '{32'd0, 32'd0, 32'd0, 1'b0}},
      '{32'd0, 32'd0, 32'h0001_0000, 32'hFFFF_FFFF, 1, '{32'd0, 32'd0, 32'd0, 1'b0}},
      // ordinary move: start, mid, exactly at the end, just past it
      '{32'd0, 32'h0064_0000, 32'h0002_0000, 32'd0, 0, '0},
      '{32'd0, 32'h0064_0000, 32'h0002_0000, 32'h0001_0000, 0, '0},
      '{32'd0, 32'h0064_0000, 32'h0002_0000, 32'h0002_0000, 0, '0},
      '{32'd0, 32'h0064_0000, 32'h0002_0000, 32'h0002_0001, 1,
        '{32'h0064_0000, 32'd0, 32'd0, 1'b0}},
      // full-range move over the shortest duration: clipping
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd0, 0, '0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd1, 0, '0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd2, 1,
        '{32'h7FFF_FFFF, 32'd0, 32'd0, 1'b0}},
      // falling move over the longest duration
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 0, '0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, '0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 0, '0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0},
      // zero duration counts as a finished move
      '{32'h0001_0000, 32'hFFFE_0000, 32'd0, 32'd0, 1,
        '{32'hFFFE_0000, 32'd0, 32'd0, 1'b0}},
      '{32'h0001_0000, 32'hFFFE_0000, 32'd0, 32'hFFFF_FFFF, 1,
        '{32'hFFFE_0000, 32'd0, 32'd0, 1'b0}},
      // small negative move, quarter and three quarters
      '{32'h0000_8000, 32'hFFFF_8000, 32'h0000_4000, 32'h0000_1000, 0, '0},
      '{32'h0000_8000, 32'hFFFF_8000, 32'h0000_4000, 32'h0000_3000, 0, '0}
    };

    in_valid_i    = 1'b0;
    sample_time_i = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_START;
    cfg_data_i    = '0;
    errors        = 0;
    cycles        = 0;
    quiet         = 1'b0;
    gap_odds      = 3;
    start_pos     = '0;
    end_pos       = '0;
    dur           = 32'h0001_0000;

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows, registers rewritten only when the move changes
    foreach (rows[i]) begin
      if (rows[i].s != start_pos || rows[i].e != end_pos || rows[i].d != dur) begin
        in_valid_i <= 1'b0;
        set_move(rows[i].s, rows[i].e, rows[i].d);
      end
      send_sample(rows[i].t, rows[i].typed, rows[i].want);
    end
    in_valid_i <= 1'b0;

    // a write to the unused index must change nothing
    drain();
    write_reg(CFG_SPARE, $urandom);
    cfg_valid_i <= 1'b0;
    send_sample(32'h0000_2000, 1'b0, none);
    in_valid_i <= 1'b0;

    // random moves; the last phase runs without any idling
    for (int ph = 0; ph < PHASES; ph++) begin
      quiet    = (ph == PHASES - 1);
      gap_odds = (ph % 3 == 1) ? 0 : $urandom_range(6, 1);
      set_move(pick_pos(), pick_pos(), pick_dur());
      for (int k = 0; k < PER_PHASE; k++) send_sample(pick_time(), 1'b0, none);
      in_valid_i <= 1'b0;
    end

    drain();
    if (errors == 0 && points_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
